FILE: rtl/cwf_pkg.sv
`timescale 1ns / 1ps

package cwf_pkg;

   typedef enum logic [1:0] {
      KIND_SYNC     = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_CHECKSUM = 2'd2
   } word_kind_type;

   localparam logic [7:0]  SYNC_LOW   = 8'h3E;   // '>'
   localparam logic [7:0]  SYNC_HIGH  = 8'h2A;   // '*'
   localparam logic [15:0] SYNC_WORD  = {SYNC_HIGH, SYNC_LOW};
   localparam logic [15:0] SUM_START  = 16'hAAAA;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       page_select;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]   frame_word;
      word_kind_type word_kind;
      logic          frame_last;
   } rsp_payload_type;

   // up to two words produced by one source byte
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type slot0;
      rsp_payload_type slot1;
   } result_pair_type;

endpackage

FILE: rtl/cwf_if.sv
`timescale 1ns / 1ps

interface cwf_req_if;
   logic                     valid;
   logic                     ready;
   cwf_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cwf_rsp_if;
   logic                     valid;
   logic                     ready;
   cwf_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cwf_core.sv
`timescale 1ns / 1ps

module cwf_core #(
   parameter int HEAD_BYTES    = 20,
   parameter int SKIP_BYTES    = 18,
   parameter int PAYLOAD_BYTES = 38
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_fire,
   input  cwf_pkg::req_payload_type  in_payload,
   output cwf_pkg::result_pair_type  results
);

   localparam int HeadEff   = (HEAD_BYTES < PAYLOAD_BYTES) ? HEAD_BYTES : PAYLOAD_BYTES;
   localparam int RecordMax = PAYLOAD_BYTES + SKIP_BYTES;
   localparam int PosW      = $clog2(RecordMax + 1);

   localparam logic [PosW-1:0] HeadPos     = PosW'(HeadEff);
   localparam logic [PosW-1:0] TailPos     = PosW'(HeadEff + SKIP_BYTES);
   localparam logic [PosW-1:0] LastPlain   = PosW'(PAYLOAD_BYTES - 1);
   localparam logic [PosW-1:0] LastSkipped = PosW'(RecordMax - 1);

   logic [PosW-1:0] pos_ff,     pos_in;
   logic            page_ff,    page_in;
   logic [15:0]     sum_ff,     sum_in;
   logic [7:0]      held_ff,    held_in;
   logic            pending_ff, pending_in;

   logic            first;
   logic            page;
   logic            used;
   logic            last;
   logic            has_payload;
   logic [7:0]      add_byte;
   logic [15:0]     sum_next;
   cwf_pkg::rsp_payload_type sync_w, payload_w, check_w;

   always_comb begin
      first    = (pos_ff == '0);
      page     = first ? in_payload.page_select : page_ff;
      used     = !page || (pos_ff < HeadPos) || (pos_ff >= TailPos);
      last     = page ? (pos_ff >= LastSkipped) : (pos_ff >= LastPlain);
      add_byte = used ? in_payload.source_byte : 8'd0;
      sum_next = sum_ff + {8'd0, add_byte};

      has_payload = (used && (pending_ff || last)) || (!used && last && pending_ff);

      sync_w.frame_word = cwf_pkg::SYNC_WORD;
      sync_w.word_kind  = cwf_pkg::KIND_SYNC;
      sync_w.frame_last = 1'b0;

      payload_w.word_kind  = cwf_pkg::KIND_PAYLOAD;
      payload_w.frame_last = 1'b0;
      if (used && pending_ff) begin
         payload_w.frame_word = {in_payload.source_byte, held_ff};
      end else if (used) begin
         payload_w.frame_word = {8'd0, in_payload.source_byte};
      end else begin
         payload_w.frame_word = {8'd0, held_ff};
      end

      check_w.frame_word = sum_next;
      check_w.word_kind  = cwf_pkg::KIND_CHECKSUM;
      check_w.frame_last = 1'b1;
   end

   // a frame start never coincides with a payload word or the frame end
   always_comb begin
      results.slot1 = check_w;
      if (first) begin
         results.slot0 = sync_w;
      end else if (has_payload) begin
         results.slot0 = payload_w;
      end else begin
         results.slot0 = check_w;
      end
      if (!in_fire) begin
         results.count = 2'd0;
      end else begin
         results.count = 2'({1'b0, first} + {1'b0, has_payload} + {1'b0, last});
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      page_in    = page_ff;
      sum_in     = sum_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      if (in_fire) begin
         page_in = page;
         if (last) begin
            pos_in     = '0;
            sum_in     = cwf_pkg::SUM_START;
            held_in    = 8'd0;
            pending_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            sum_in = sum_next;
            if (used) begin
               if (pending_ff) begin
                  held_in    = 8'd0;
                  pending_in = 1'b0;
               end else begin
                  held_in    = in_payload.source_byte;
                  pending_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         page_ff    <= 1'b0;
         sum_ff     <= cwf_pkg::SUM_START;
         held_ff    <= 8'd0;
         pending_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         page_ff    <= page_in;
         sum_ff     <= sum_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
      end
   end

endmodule

FILE: rtl/cwf_queue.sv
`timescale 1ns / 1ps

module cwf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  cwf_pkg::result_pair_type  wr,
   output logic                      space_ok,
   output logic                      rd_valid,
   input  logic                      rd_ready,
   output cwf_pkg::rsp_payload_type  rd_data
);

   cwf_pkg::rsp_payload_type entry_ff [cwf_pkg::QUEUE_DEPTH];

   logic [cwf_pkg::QUEUE_AW-1:0] wptr_ff,  wptr_in;
   logic [cwf_pkg::QUEUE_AW-1:0] rptr_ff,  rptr_in;
   logic [cwf_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic [cwf_pkg::QUEUE_AW-1:0] wptr_next;
   logic                         pop;

   assign rd_valid  = (count_ff != '0);
   assign rd_data   = entry_ff[rptr_ff];
   assign pop       = rd_valid && rd_ready;
   // room for the two words a byte can cause
   assign space_ok  = (count_ff <= cwf_pkg::QUEUE_CW'(cwf_pkg::QUEUE_DEPTH - 2));
   assign wptr_next = wptr_ff + 1'b1;

   always_comb begin
      wptr_in  = wptr_ff + cwf_pkg::QUEUE_AW'(wr.count);
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + cwf_pkg::QUEUE_CW'(wr.count) - cwf_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         entry_ff[wptr_ff] <= wr.slot0;
      end
      if (wr.count == 2'd2) begin
         entry_ff[wptr_next] <= wr.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/checksummed_word_framer_top.sv
`timescale 1ns / 1ps

// Checksummed word framer.
// req_if carries one source byte and a page select per transaction; rsp_if
// carries 16-bit frame words (earlier byte in the low half) with a word kind
// and a last flag on the checksum word that closes each frame.
// A frame is the sync word, the used source bytes packed two per word, then
// a 16-bit checksum that starts at 0xAAAA and adds every used byte.
// The page select is sampled on each frame's first byte; page 1 drops
// SKIP_BYTES bytes after the first HEAD_BYTES bytes.
// A byte's words are written into the result queue and are offered on rsp_if
// from its registers. The framer takes one byte per cycle while req_if.ready is
// high; the byte that ends a frame can cause two words (last payload word and
// checksum), which the four-entry result queue absorbs.
// req_if.ready is low while the queue holds more than two words, so a
// stalled receiver stops the source once three words are waiting; bytes
// that cause no word keep passing until then.
// Reset clears the frame position, page, checksum and the result queue; the
// next byte after reset begins a new frame.
module checksummed_word_framer_top #(
   parameter int HEAD_BYTES    = 20,
   parameter int SKIP_BYTES    = 18,
   parameter int PAYLOAD_BYTES = 38
) (
   input logic        clock,
   input logic        reset,
   cwf_req_if.sink    req_if,
   cwf_rsp_if.source  rsp_if
);

   cwf_pkg::result_pair_type results;
   logic                     space_ok;
   logic                     req_fire;

   assign req_if.ready = space_ok;
   assign req_fire     = req_if.valid && space_ok;

   cwf_core #(
      .HEAD_BYTES    (HEAD_BYTES),
      .SKIP_BYTES    (SKIP_BYTES),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (req_fire),
      .in_payload (req_if.payload),
      .results    (results)
   );

   cwf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (results),
      .space_ok (space_ok),
      .rd_valid (rsp_if.valid),
      .rd_ready (rsp_if.ready),
      .rd_data  (rsp_if.payload)
   );

endmodule

FILE: test/checksummed_word_framer_top_test.sv
`timescale 1ns / 1ps

module checksummed_word_framer_top_test;
   import cwf_pkg::*;

   localparam int HEAD_BYTES      = 20;
   localparam int SKIP_BYTES      = 18;
   localparam int PAYLOAD_BYTES   = 38;
   localparam int HEAD_USED       = (HEAD_BYTES < PAYLOAD_BYTES) ? HEAD_BYTES : PAYLOAD_BYTES;
   localparam int DIRECTED_ROWS   = 24;
   localparam int RANDOM_ITEMS    = 1600;
   localparam int HOLD_OFF_ITEM   = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_ITEM      = 1000;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int CYCLE_LIMIT     = 500000;

   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_NO_WORD,
      ROW_ONE_WORD
   } row_check_type;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS
   } byte_fill_type;

   typedef struct packed {
      logic [7:0]      source_byte;
      logic            page_select;
      row_check_type   check;
      rsp_payload_type word;
   } stim_row_type;

   logic clock;
   logic reset;

   cwf_req_if req_bus ();
   cwf_rsp_if rsp_bus ();

   checksummed_word_framer_top #(
      .HEAD_BYTES    (HEAD_BYTES),
      .SKIP_BYTES    (SKIP_BYTES),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // one page 1 frame, positions 0 to 23; the last four fall in the dropped span
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h3C, 1'b1, ROW_ONE_WORD, rsp_payload_type'{SYNC_WORD, KIND_SYNC, 1'b0}},
      '{8'hC3, 1'b0, ROW_ONE_WORD, rsp_payload_type'{16'hC33C, KIND_PAYLOAD, 1'b0}},
      '{8'hFF, 1'b0, ROW_NO_WORD, '0},
      '{8'hFF, 1'b1, ROW_ONE_WORD, rsp_payload_type'{16'hFFFF, KIND_PAYLOAD, 1'b0}},
      '{8'h00, 1'b0, ROW_NO_WORD, '0},
      '{8'h00, 1'b0, ROW_ONE_WORD, rsp_payload_type'{16'h0000, KIND_PAYLOAD, 1'b0}},
      '{8'h01, 1'b1, ROW_NO_WORD, '0},
      '{8'h80, 1'b0, ROW_ONE_WORD, rsp_payload_type'{16'h8001, KIND_PAYLOAD, 1'b0}},
      '{8'h7F, 1'b0, ROW_NO_WORD, '0},
      '{8'hFE, 1'b1, ROW_ONE_WORD, rsp_payload_type'{16'hFE7F, KIND_PAYLOAD, 1'b0}},
      '{8'h12, 1'b0, ROW_PREDICTED, '0},
      '{8'h34, 1'b1, ROW_PREDICTED, '0},
      '{8'h56, 1'b0, ROW_PREDICTED, '0},
      '{8'h78, 1'b1, ROW_PREDICTED, '0},
      '{8'h9A, 1'b0, ROW_PREDICTED, '0},
      '{8'hBC, 1'b1, ROW_PREDICTED, '0},
      '{8'hDE, 1'b0, ROW_PREDICTED, '0},
      '{8'hF0, 1'b1, ROW_PREDICTED, '0},
      '{8'h0F, 1'b0, ROW_PREDICTED, '0},
      '{8'hE1, 1'b1, ROW_PREDICTED, '0},
      '{8'hFF, 1'b0, ROW_NO_WORD, '0},
      '{8'h00, 1'b1, ROW_NO_WORD, '0},
      '{8'hA5, 1'b0, ROW_NO_WORD, '0},
      '{8'h5A, 1'b1, ROW_NO_WORD, '0}
   };

   // framer state as the predictor sees it
   logic [5:0]  frame_pos     = '0;
   logic        frame_page    = 1'b0;
   logic [15:0] frame_sum     = SUM_START;
   logic [7:0]  low_byte      = '0;
   logic        low_byte_held = 1'b0;

   rsp_payload_type step_words[$];
   rsp_payload_type pending_frame_words[$];
   rsp_payload_type want;

   int frames_done [0:1] = '{0, 0};
   int accepted_count    = 0;
   int checked_count     = 0;
   int fail_count        = 0;
   int cycle_count       = 0;
   int hold_off_done     = 0;

   logic steady             = 1'b0;
   logic hold_off_requested = 1'b0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // words caused by one source byte, left in step_words
   function automatic void predict_frame_words(input logic [7:0] data, input logic page);
      int   record_len;
      logic used;
      logic last;
      step_words.delete();
      if (frame_pos == 0) begin
         frame_page = page;
         step_words.push_back(rsp_payload_type'{SYNC_WORD, KIND_SYNC, 1'b0});
      end
      record_len = frame_page ? PAYLOAD_BYTES + SKIP_BYTES : PAYLOAD_BYTES;
      used = !frame_page || int'(frame_pos) < HEAD_USED ||
             int'(frame_pos) >= HEAD_USED + SKIP_BYTES;
      last = int'(frame_pos) + 1 >= record_len;
      if (used) begin
         frame_sum = frame_sum + 16'(data);
         if (low_byte_held) begin
            step_words.push_back(rsp_payload_type'{{data, low_byte}, KIND_PAYLOAD, 1'b0});
            low_byte_held = 1'b0;
            low_byte = '0;
         end else if (last) begin
            step_words.push_back(rsp_payload_type'{{8'h00, data}, KIND_PAYLOAD, 1'b0});
         end else begin
            low_byte = data;
            low_byte_held = 1'b1;
         end
      end
      if (last) begin
         // odd payload: the lone byte goes out with a zero high half
         if (low_byte_held) begin
            step_words.push_back(rsp_payload_type'{{8'h00, low_byte}, KIND_PAYLOAD, 1'b0});
         end
         step_words.push_back(rsp_payload_type'{frame_sum, KIND_CHECKSUM, 1'b1});
         frames_done[frame_page]++;
         frame_pos = '0;
         frame_sum = SUM_START;
         low_byte = '0;
         low_byte_held = 1'b0;
      end else begin
         frame_pos = frame_pos + 6'd1;
      end
   endfunction

   task automatic send_source_byte(input logic [7:0] data, input logic page);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= req_payload_type'{source_byte: data, page_select: page};
      do @(posedge clock); while (!req_bus.ready);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("checksummed_word_framer_top test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_frame_words(req_bus.payload.source_byte, req_bus.payload.page_select);
            if (accepted_count < DIRECTED_ROWS &&
                directed_rows[accepted_count].check != ROW_PREDICTED) begin
               if (directed_rows[accepted_count].check == ROW_ONE_WORD) begin
                  pending_frame_words.push_back(directed_rows[accepted_count].word);
               end
            end else begin
               foreach (step_words[k]) pending_frame_words.push_back(step_words[k]);
            end
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_frame_words.size() == 0) begin
               $error("unexpected frame word %h kind %0d last %0d",
                      rsp_bus.payload.frame_word, rsp_bus.payload.word_kind,
                      rsp_bus.payload.frame_last);
               fail_count++;
            end else begin
               want = pending_frame_words.pop_front();
               if (want.frame_word !== rsp_bus.payload.frame_word) begin
                  $error("frame_word expected %h got %h",
                         want.frame_word, rsp_bus.payload.frame_word);
                  fail_count++;
               end
               if (want.word_kind !== rsp_bus.payload.word_kind) begin
                  $error("word_kind expected %0d got %0d",
                         want.word_kind, rsp_bus.payload.word_kind);
                  fail_count++;
               end
               if (want.frame_last !== rsp_bus.payload.frame_last) begin
                  $error("frame_last expected %0d got %0d",
                         want.frame_last, rsp_bus.payload.frame_last);
                  fail_count++;
               end
               checked_count++;
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_requested) begin
            hold_off_requested = 1'b0;
            rsp_bus.ready <= 1'b0;
            while (hold_off_done < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               hold_off_done++;
            end
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = steady ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int            send_pos;
      int            send_len;
      int            waited;
      int            roll;
      logic [7:0]    data;
      logic          page;
      byte_fill_type fill;

      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_source_byte(directed_rows[r].source_byte, directed_rows[r].page_select);
      end

      // the directed rows leave a page 1 frame unfinished
      send_pos = DIRECTED_ROWS;
      send_len = PAYLOAD_BYTES + SKIP_BYTES;
      fill = FILL_RANDOM;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == HOLD_OFF_ITEM) hold_off_requested = 1'b1;
         if (i == DRAIN_ITEM) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_frame_words.size() != 0) @(posedge clock);
         end
         page = 1'($urandom_range(0, 1));
         if (send_pos == 0) begin
            send_len = page ? PAYLOAD_BYTES + SKIP_BYTES : PAYLOAD_BYTES;
            roll = $urandom_range(0, 9);
            fill = (roll < 6) ? FILL_RANDOM : (roll < 8) ? FILL_ONES : FILL_ZEROS;
         end
         case (fill)
            FILL_ONES:  data = 8'hFF;
            FILL_ZEROS: data = 8'h00;
            default:    data = 8'($urandom);
         endcase
         send_source_byte(data, page);
         send_pos = (send_pos + 1 == send_len) ? 0 : send_pos + 1;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_frame_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_frame_words.size() != 0) begin
         $error("%0d frame words never arrived", pending_frame_words.size());
         fail_count++;
      end

      $display("covered %0d source bytes in %0d page 0 and %0d page 1 frames, %0d words checked",
               accepted_count, frames_done[0], frames_done[1], checked_count);
      $display("receiver held off for %0d cycles in one stretch; output drained once mid-run",
               hold_off_done);
      if (fail_count == 0) begin
         $display("checksummed_word_framer_top test passed");
      end else begin
         $display("checksummed_word_framer_top test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/cwf_pkg.sv
rtl/cwf_if.sv
rtl/cwf_core.sv
rtl/cwf_queue.sv
rtl/checksummed_word_framer_top.sv
test/checksummed_word_framer_top_test.sv
